// ===== sv/dbdt_pkg.sv =====
// package for the double buffer dirty tracker: sizes, codes and the
// controller/datapath command and status structs; no dependencies
`default_nettype none

package dbdt_pkg;

    localparam int NUM_REGIONS    = 16;
    localparam int IDX_W          = $clog2(NUM_REGIONS);
    localparam int REGION_W       = 4;
    localparam int REGION_COUNT_W = 5;
    localparam int ACTION_W       = 2;
    localparam int COMMAND_W      = 2;

    localparam logic [ACTION_W-1:0] ACT_MARK_FRAME  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MARK_REGION = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLIP        = 2'd2;

    localparam logic [COMMAND_W-1:0] CMD_FRAME  = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_REGION = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_FLIP   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic set_main;     // mark whole frame changed
        logic mark;         // mark the input region changed
        logic scan_init;    // rewind the region scan
        logic scan_region;  // emit region copy, update its flags, advance
        logic scan_skip;    // advance past a clean region
        logic frame_copy;   // emit frame copy, update the frame flag and the region flags below the count
        logic flip;         // emit the closing flip command
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic main_changed;
        logic main_pending;
        logic scan_done;
        logic scan_hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/dbdt_if.sv =====
// valid/ready channel interfaces for the tracker's input, output and
// configuration ports; depends on dbdt_pkg
`default_nettype none

interface dbdt_in_if;
    logic                          valid;
    logic                          ready;
    logic [dbdt_pkg::ACTION_W-1:0] action;
    logic [dbdt_pkg::REGION_W-1:0] region;

    modport source (output valid, output action, output region, input ready);
    modport sink (input valid, input action, input region, output ready);
endinterface

interface dbdt_out_if;
    logic                           valid;
    logic                           ready;
    logic [dbdt_pkg::COMMAND_W-1:0] command;
    logic [dbdt_pkg::REGION_W-1:0]  region_out;
    logic                           last;

    modport source (output valid, output command, output region_out, output last,
                    input ready);
    modport sink (input valid, input command, input region_out, input last,
                  output ready);
endinterface

interface dbdt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dbdt_pkg::REGION_COUNT_W-1:0] region_count;

    modport source (output valid, output region_count, input ready);
    modport sink (input valid, input region_count, output ready);
endinterface

`default_nettype wire

// ===== sv/dbdt_ctrl.sv =====
// controller state machine of the tracker: decodes actions and sequences
// a flip; depends on dbdt_pkg
`default_nettype none

module dbdt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [dbdt_pkg::ACTION_W-1:0] in_action,
    output logic                               in_ready,
    input  wire dbdt_pkg::dp_status_t          status,
    output dbdt_pkg::dp_cmd_t                  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FRAME = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLIP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_action)
                        dbdt_pkg::ACT_MARK_FRAME:  cmd.set_main = 1'b1;
                        dbdt_pkg::ACT_MARK_REGION: cmd.mark = 1'b1;
                        dbdt_pkg::ACT_FLIP:
                        begin
                            cmd.scan_init = 1'b1;
                            if (status.main_changed || status.main_pending)
                                state_next = ST_FRAME;
                            else
                                state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FRAME:
            begin
                if (status.out_free)
                begin
                    cmd.frame_copy = 1'b1;
                    state_next     = ST_FLIP;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_FLIP;
                else if (!status.scan_hit)
                    cmd.scan_skip = 1'b1;
                else if (status.out_free)
                    cmd.scan_region = 1'b1;
            end
            ST_FLIP:
            begin
                if (status.out_free)
                begin
                    cmd.flip   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== sv/dbdt_dp.sv =====
// datapath of the tracker: region count register, frame and region flags,
// scan index and output register; depends on dbdt_pkg
`default_nettype none

module dbdt_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dbdt_pkg::dp_cmd_t                   cmd,
    output dbdt_pkg::dp_status_t                     status,
    input  wire logic [dbdt_pkg::REGION_W-1:0]       in_region,
    input  wire logic                                cfg_valid,
    input  wire logic [dbdt_pkg::REGION_COUNT_W-1:0] cfg_region_count,
    output logic                                     cfg_ready,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [dbdt_pkg::COMMAND_W-1:0]           out_command,
    output logic [dbdt_pkg::REGION_W-1:0]            out_region,
    output logic                                     out_last
);

    localparam int N  = dbdt_pkg::NUM_REGIONS;
    localparam int CW = dbdt_pkg::REGION_COUNT_W;

    logic [CW-1:0] region_count_reg;
    logic [CW-1:0] n_eff;
    logic          main_changed_reg, main_changed_next;
    logic          main_pending_reg, main_pending_next;
    logic [N-1:0]  changed_reg, changed_next;
    logic [N-1:0]  pending_reg, pending_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [dbdt_pkg::IDX_W-1:0] scan_sel;

    logic                           out_valid_reg, out_valid_next;
    logic [dbdt_pkg::COMMAND_W-1:0] out_command_reg, out_command_next;
    logic [dbdt_pkg::REGION_W-1:0]  out_region_reg, out_region_next;
    logic                           out_last_reg, out_last_next;

    assign cfg_ready = 1'b1;

    // count saturated at the number of regions
    assign n_eff = (region_count_reg > CW'(N)) ? CW'(N) : region_count_reg;
    assign scan_sel = scan_idx_reg[dbdt_pkg::IDX_W-1:0];

    assign status.main_changed = main_changed_reg;
    assign status.main_pending = main_pending_reg;
    assign status.scan_done    = (scan_idx_reg >= n_eff);
    assign status.scan_hit     = changed_reg[scan_sel] || pending_reg[scan_sel];
    assign status.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        main_changed_next = main_changed_reg;
        main_pending_next = main_pending_reg;
        changed_next      = changed_reg;
        pending_next      = pending_reg;
        scan_idx_next     = scan_idx_reg;

        if (cmd.set_main)
            main_changed_next = 1'b1;

        if (cmd.mark && (CW'(in_region) < n_eff))
            changed_next[in_region[dbdt_pkg::IDX_W-1:0]] = 1'b1;

        if (cmd.scan_init)
            scan_idx_next = '0;

        if (cmd.scan_skip)
            scan_idx_next = scan_idx_reg + CW'(1);

        if (cmd.scan_region)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
            if (changed_reg[scan_sel])
            begin
                changed_next[scan_sel] = 1'b0;
                pending_next[scan_sel] = 1'b1;
            end
            else
            begin
                pending_next[scan_sel] = 1'b0;
            end
        end

        if (cmd.frame_copy)
        begin
            if (main_changed_reg)
            begin
                main_changed_next = 1'b0;
                main_pending_next = 1'b1;
            end
            else
            begin
                main_pending_next = 1'b0;
            end
            for (int i = 0; i < N; i++)
            begin
                if (CW'(i) < n_eff)
                begin
                    pending_next[i] = main_changed_reg ? 1'b0 : changed_reg[i];
                    changed_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_command_next = out_command_reg;
        out_region_next  = out_region_reg;
        out_last_next    = out_last_reg;
        if (cmd.frame_copy)
        begin
            out_valid_next   = 1'b1;
            out_command_next = dbdt_pkg::CMD_FRAME;
            out_region_next  = '0;
            out_last_next    = 1'b0;
        end
        else if (cmd.scan_region)
        begin
            out_valid_next   = 1'b1;
            out_command_next = dbdt_pkg::CMD_REGION;
            out_region_next  = dbdt_pkg::REGION_W'(scan_sel);
            out_last_next    = 1'b0;
        end
        else if (cmd.flip)
        begin
            out_valid_next   = 1'b1;
            out_command_next = dbdt_pkg::CMD_FLIP;
            out_region_next  = '0;
            out_last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_count_reg <= '0;
            main_changed_reg <= 1'b0;
            main_pending_reg <= 1'b0;
            changed_reg      <= '0;
            pending_reg      <= '0;
            scan_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                region_count_reg <= cfg_region_count;
            main_changed_reg <= main_changed_next;
            main_pending_reg <= main_pending_next;
            changed_reg      <= changed_next;
            pending_reg      <= pending_next;
            scan_idx_reg     <= scan_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_command_reg <= out_command_next;
        out_region_reg  <= out_region_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_command = out_command_reg;
    assign out_region  = out_region_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/double_buffer_dirty_tracker.sv =====
// top level of the double buffer dirty tracker: joins controller and
// datapath to the channels; depends on dbdt_pkg, dbdt_if, dbdt_ctrl, dbdt_dp
`default_nettype none

// the tracker records which parts of a double-buffered display have
// changed and, on each flip transaction, issues the copy commands that
// bring the other buffer up to date, ending with a flip command that has
// last set. a mark transaction (whole frame or one region) gives no
// result; region marks at or above the saturated region count are
// dropped. a flip is sequenced by the controller: with a changed or
// pending frame it steps through accept, frame copy and flip; else the
// scan index walks the regions below the count one per cycle while the
// output sink does not stall, then the flip follows. input is taken
// again once the flip command is in the output register; the single
// output register lets marks be taken while that flip command waits.
// region_count must be written through the always-ready configuration
// channel only while the block idles; the block does not enforce this.

module double_buffer_dirty_tracker (
    input wire logic clk,
    input wire logic rst_n,
    dbdt_in_if.sink    in_ch,
    dbdt_out_if.source out_ch,
    dbdt_cfg_if.sink   cfg
);

    dbdt_pkg::dp_cmd_t    cmd;
    dbdt_pkg::dp_status_t status;

    // action decode and flip sequencing
    dbdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // flags, count register, scan index and output register
    dbdt_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_region        (in_ch.region),
        .cfg_valid        (cfg.valid),
        .cfg_region_count (cfg.region_count),
        .cfg_ready        (cfg.ready),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_command      (out_ch.command),
        .out_region       (out_ch.region_out),
        .out_last         (out_ch.last)
    );

    // last marks exactly the flip command
    a_last_is_flip: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last == (out_ch.command == dbdt_pkg::CMD_FLIP)))
        else $error("last does not match flip command");

    // only region copies carry a region number
    a_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.command != dbdt_pkg::CMD_REGION))
            |-> (out_ch.region_out == '0))
        else $error("region_out not zero outside a region copy");

    // an accepted flip blocks input for at least the next cycle
    a_flip_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.action == dbdt_pkg::ACT_FLIP))
            |=> !in_ch.ready)
        else $error("input taken right after a flip transaction");

endmodule

`default_nettype wire
